// ===== hdl/etsk_pkg.sv =====
// ----------------------------------------------------------------------------
// etsk_pkg
// Shared types and constants for the edge-timed serial key decoder.
// ----------------------------------------------------------------------------
package etsk_pkg;

  localparam int unsigned ElapsedW  = 24;
  localparam int unsigned PeriodW   = 16;
  // Numerator width: elapsed time plus half a bit period
  localparam int unsigned NumW      = ElapsedW + 1;
  localparam int unsigned DivCntW   = $clog2(NumW);

  localparam logic [PeriodW-1:0] BitPeriodReset = 16'd100;

  localparam logic [7:0] KeyPressMax    = 8'd77;
  localparam logic [7:0] KeyReleaseMax  = 8'd155;
  localparam logic [7:0] KeyReleaseBase = 8'd78;

  typedef enum logic [1:0] {
    EV_PRESS     = 2'd0,
    EV_RELEASE   = 2'd1,
    EV_OTHER     = 2'd2,
    EV_FRAME_ERR = 2'd3
  } event_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DIV   = 3'b010,
    ST_APPLY = 3'b100
  } ctrl_state_e;

  typedef struct packed {
    logic take;   // input transfer this cycle
    logic step;   // advance the divider by one quotient bit
    logic apply;  // commit the run to the frame state
  } dp_cmd_t;

  typedef struct packed {
    logic frame_active;
    logic last_step;
    logic emit;       // applying now would produce a result
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

endpackage

// ===== hdl/etsk_ctrl.sv =====
// ----------------------------------------------------------------------------
// etsk_ctrl
// Sequencer: accepts an edge, runs the divider, then commits the run.
// ----------------------------------------------------------------------------
module etsk_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  etsk_pkg::dp_status_t  status_i,
  output etsk_pkg::dp_cmd_t     cmd_o
);

  etsk_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      etsk_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
        // Edges with no frame open are settled on the spot
        if (in_valid_i && status_i.frame_active) begin
          state_d = etsk_pkg::ST_DIV;
        end
      end
      etsk_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = etsk_pkg::ST_APPLY;
        end
      end
      etsk_pkg::ST_APPLY: begin
        // Hold while a result would overwrite one not yet taken
        if (!status_i.emit || status_i.out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = etsk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = etsk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etsk_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/etsk_dp.sv =====
// ----------------------------------------------------------------------------
// etsk_dp
// Datapath: bit period register, restoring divider, frame state, result reg.
// ----------------------------------------------------------------------------
module etsk_dp #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [etsk_pkg::PeriodW-1:0]        cfg_wdata_i,
  input  logic                                line_high_i,
  input  logic [etsk_pkg::ElapsedW-1:0]       elapsed_us_i,
  input  logic                                out_stall_i,
  input  etsk_pkg::dp_cmd_t                   cmd_i,
  output etsk_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  output logic [1:0]                          event_kind_o,
  output logic [6:0]                          key_index_o,
  output logic [7:0]                          raw_byte_o
);

  localparam int unsigned CntW = $clog2(DATA_BITS + 1);
  localparam int unsigned NumW = etsk_pkg::NumW;
  localparam int unsigned PW   = etsk_pkg::PeriodW;

  logic [PW-1:0]                 period_q;
  logic                          line_q;
  logic [PW-1:0]                 rem_q, rem_d;
  logic [NumW-1:0]               quo_q, quo_d;
  logic [etsk_pkg::DivCntW-1:0]  div_cnt_q;
  logic                          frame_active_q;
  logic                          start_rm_q;
  logic [CntW-1:0]               bit_cnt_q;
  logic [DATA_BITS-1:0]          store_q;
  logic                          out_valid_q;
  etsk_pkg::event_kind_e         kind_q;
  logic [6:0]                    key_q;
  logic [7:0]                    byte_q;

  logic [PW-1:0]                 divisor;
  logic [NumW-1:0]               numer;
  logic [PW:0]                   rem_sh, diff;
  logic                          ge;
  logic                          dec_start;
  logic [NumW-1:0]               runs;
  logic [CntW-1:0]               remain;
  logic                          overflow;
  logic [CntW-1:0]               new_cnt;
  logic                          complete;
  logic                          emit;
  logic [DATA_BITS-1:0]          run_mask;
  logic [DATA_BITS-1:0]          store_next;
  logic [7:0]                    byte_next;
  etsk_pkg::event_kind_e         kind_next;
  logic [6:0]                    key_next;
  logic                          out_free;

  // A zero bit period counts as one
  assign divisor = (period_q == '0) ? PW'(1) : period_q;
  assign numer   = NumW'(elapsed_us_i) + NumW'(divisor >> 1);

  // One restoring-division step per cycle, quotient shifts in from the right
  assign rem_sh = {rem_q, quo_q[NumW-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign ge     = rem_sh >= {1'b0, divisor};
  assign rem_d  = ge ? diff[PW-1:0] : rem_sh[PW-1:0];
  assign quo_d  = {quo_q[NumW-2:0], ge};

  // Run bookkeeping on the finished quotient
  assign dec_start = line_q && !start_rm_q && (quo_q != '0);
  assign runs      = dec_start ? (quo_q - NumW'(1)) : quo_q;
  assign remain    = CntW'(DATA_BITS) - bit_cnt_q;
  assign overflow  = runs > NumW'(remain);
  assign new_cnt   = bit_cnt_q + runs[CntW-1:0];
  assign complete  = !overflow && (new_cnt == CntW'(DATA_BITS));
  assign emit      = overflow || complete;

  always_comb begin
    for (int p = 0; p < DATA_BITS; p++) begin
      run_mask[p] = (CntW'(p) >= bit_cnt_q) && (CntW'(p) < new_cnt);
    end
  end

  assign store_next = line_q ? (store_q & ~run_mask) : (store_q | run_mask);
  assign byte_next  = 8'(store_next);

  always_comb begin
    if (overflow) begin
      kind_next = etsk_pkg::EV_FRAME_ERR;
      key_next  = '0;
    end else if (byte_next <= etsk_pkg::KeyPressMax) begin
      kind_next = etsk_pkg::EV_PRESS;
      key_next  = byte_next[6:0];
    end else if (byte_next <= etsk_pkg::KeyReleaseMax) begin
      kind_next = etsk_pkg::EV_RELEASE;
      key_next  = 7'(byte_next - etsk_pkg::KeyReleaseBase);
    end else begin
      kind_next = etsk_pkg::EV_OTHER;
      key_next  = '0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q       <= etsk_pkg::BitPeriodReset;
      frame_active_q <= 1'b0;
      start_rm_q     <= 1'b0;
      bit_cnt_q      <= '0;
      store_q        <= '0;
      div_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      // Load a new result, or drop the held one once it transfers out
      if (cmd_i.apply && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.take) begin
        div_cnt_q <= '0;
        // Falling edge while idle opens a frame; rising edge is dropped
        if (!frame_active_q && !line_high_i) begin
          frame_active_q <= 1'b1;
          start_rm_q     <= 1'b0;
          bit_cnt_q      <= '0;
        end
      end
      if (cmd_i.step) begin
        div_cnt_q <= div_cnt_q + etsk_pkg::DivCntW'(1);
      end
      if (cmd_i.apply) begin
        if (dec_start) begin
          start_rm_q <= 1'b1;
        end
        if (overflow) begin
          frame_active_q <= 1'b0;
        end else begin
          store_q   <= store_next;
          bit_cnt_q <= new_cnt;
          if (complete) begin
            frame_active_q <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      line_q <= line_high_i;
      rem_q  <= '0;
      quo_q  <= numer;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (cmd_i.apply && emit) begin
      kind_q <= kind_next;
      key_q  <= key_next;
      byte_q <= overflow ? 8'd0 : byte_next;
    end
  end

  assign status_o.frame_active = frame_active_q;
  assign status_o.last_step    = div_cnt_q == etsk_pkg::DivCntW'(NumW - 1);
  assign status_o.emit         = emit;
  assign status_o.out_free     = out_free;

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign key_index_o  = key_q;
  assign raw_byte_o   = byte_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= CntW'(DATA_BITS))
    else $error("bit count beyond frame length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && emit) |-> out_free)
    else $error("result overwrote an untaken result");

  a_step_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> frame_active_q)
    else $error("divider running with no frame open");

  a_emit_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && emit) |=> (!frame_active_q && out_valid_q))
    else $error("frame still open after result");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.apply))
    else $error("result appeared without a commit");

endmodule

// ===== hdl/edge_timed_serial_key_decoder.sv =====
// Timing: an edge inside a frame goes from its input transfer through the
//   divider, one step per numerator bit, to the commit that loads the output
//   register; the commit waits while it would overwrite an untaken result.
//   The sequencer takes no new edge until that commit; an edge that opens a
//   frame or is dropped while idle is settled in the idle state.
//   Reset: asynchronous, active low.
// ----------------------------------------------------------------------------
// edge_timed_serial_key_decoder
// Rebuilds 8N1-style serial frames from timed line edges and reports key
// press, key release, other-byte and framing-error events.
// ----------------------------------------------------------------------------
module edge_timed_serial_key_decoder #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: bit period in microseconds
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Edge input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        line_high_i,
  input  logic [23:0] elapsed_us_i,
  // Event output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [6:0]  key_index_o,
  output logic [7:0]  raw_byte_o
);

  // Commands from the sequencer and status back from the datapath
  etsk_pkg::dp_cmd_t    cmd;
  etsk_pkg::dp_status_t status;

  // The sequencer takes one edge at a time; the output register holds a
  // finished event, so a new edge may transfer in while it waits.
  // After reset: idle, no frame open, bit period 100 us.
  etsk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Divider, bit assembly, key classification and the result register
  etsk_dp #(
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .line_high_i  (line_high_i),
    .elapsed_us_i (elapsed_us_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .event_kind_o (event_kind_o),
    .key_index_o  (key_index_o),
    .raw_byte_o   (raw_byte_o)
  );

endmodule
